// ===== design/fcts_pkg.sv =====
// Shared constants, codes and types for the function call trace stack.
`timescale 1ns / 1ps

package fcts_pkg;

	localparam int STACK_DEPTH  = 1024;
	localparam int FUNC_ID_BITS = 16;
	localparam int ADDR_BITS    = 32;
	localparam int INSN_BITS    = 32;
	localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W        = $clog2(STACK_DEPTH);

	localparam logic [FUNC_ID_BITS-1:0] MACHINE_ID = '1;

	localparam logic [INSN_BITS-1:0] JALR_SEL = 32'h0000_707F;
	localparam logic [INSN_BITS-1:0] JALR_KEY = 32'h0000_0067;
	localparam logic [INSN_BITS-1:0] JAL_SEL  = 32'h0000_007F;
	localparam logic [INSN_BITS-1:0] JAL_KEY  = 32'h0000_006F;

	localparam logic [4:0] REG_ZERO = 5'd0;
	localparam logic [4:0] REG_RA   = 5'd1;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_RETURN   = 3'd1,
		EV_DIRECT   = 3'd2,
		EV_INDIRECT = 3'd3,
		EV_TAIL     = 3'd4
	} ev_kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_NON_CALL  = 2'd3
	} status_t;

	typedef struct packed {
		logic [FUNC_ID_BITS-1:0] caller;
		logic [FUNC_ID_BITS-1:0] callee;
	} frame_t;

	typedef struct packed {
		ev_kind_t                event_kind;
		logic [FUNC_ID_BITS-1:0] caller_id;
		logic [FUNC_ID_BITS-1:0] callee_id;
		logic [ADDR_BITS-1:0]    event_target;
		logic [CNT_W-1:0]        stack_depth;
		status_t                 status;
	} result_t;

endpackage

// ===== design/fcts_stack_ram.sv =====
// Simple dual-port stack memory with registered read data.
`timescale 1ns / 1ps

module fcts_stack_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== design/fcts_out_buf.sv =====
// Two-entry output buffer: output register plus skid slot.
`timescale 1ns / 1ps

module fcts_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fcts_pkg::result_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output fcts_pkg::result_t out_data
);

	logic              out_valid_q;
	logic              skid_valid_q;
	fcts_pkg::result_t out_q;
	fcts_pkg::result_t skid_q;
	logic              load;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign load      = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && !skid_valid_q) begin
			// park the word while the output is stalled
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= skid_valid_q ? skid_q : in_data;
		end
		if (!load && !skid_valid_q) begin
			skid_q <= in_data;
		end
	end

endmodule

// ===== design/function_call_trace_stack.sv =====
// Result words are registered in the output buffer, or held in its skid slot on a stall.
// Throughput: one word per cycle while input ready is high; the top frame sits in
// registers, the frame below it is prefetched from the stack memory with write-to-read forwarding.
// Output stalls are absorbed by a two-entry buffer before input ready drops.
// Reset: depth one, frame (machine, id 0), start id 0; no memory clearing pass.
`timescale 1ns / 1ps

module function_call_trace_stack (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,  // start_function_id
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] instruction, [63:32] target_address, [79:64] target_function_id
	input  logic [79:0] s_tdata,
	input  logic [0:0]  s_tuser,    // [0] target_is_function
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] caller_id, [31:16] callee_id, [63:32] event_target,
	// [74:64] stack_depth, [76:75] status, [79:77] zero
	output logic [79:0] m_tdata,
	output logic [2:0]  m_tuser     // [2:0] event_kind
);

	localparam int FB = fcts_pkg::FUNC_ID_BITS;
	localparam int AB = fcts_pkg::ADDR_BITS;
	localparam int CW = fcts_pkg::CNT_W;
	localparam int PW = fcts_pkg::PTR_W;

	logic [fcts_pkg::INSN_BITS-1:0] insn;
	logic [AB-1:0]                  target;
	logic                           is_func;
	logic [FB-1:0]                  new_id;
	logic [4:0]                     rd;
	logic [4:0]                     rs1;
	logic [11:0]                    imm;
	logic                           is_jal;
	logic                           is_jalr;
	logic                           is_ret;
	logic                           accept;

	logic [CW-1:0]     count_q;
	fcts_pkg::frame_t  top_q;
	logic              empty;
	logic              full;
	logic [FB-1:0]     tcallee;
	logic [FB-1:0]     tcaller;

	fcts_pkg::frame_t  below;
	fcts_pkg::frame_t  ram_rdata;
	fcts_pkg::frame_t  fwd_data_q;
	logic              fwd_q;
	logic              wr_en;
	logic [PW-1:0]     wr_addr;
	logic [PW-1:0]     rd_addr;
	logic [CW-1:0]     count_next;
	logic [CW-1:0]     rd_ptr;

	logic              do_push;
	logic              do_pop;
	logic              do_tail;
	fcts_pkg::result_t res;
	fcts_pkg::result_t out_data;
	logic              buf_ready;

	assign insn    = s_tdata[31:0];
	assign target  = s_tdata[63:32];
	assign new_id  = s_tdata[79:64];
	assign is_func = s_tuser[0];
	assign rd      = insn[11:7];
	assign rs1     = insn[19:15];
	assign imm     = insn[31:20];
	assign is_jal  = (insn & fcts_pkg::JAL_SEL) == fcts_pkg::JAL_KEY;
	assign is_jalr = !is_jal && ((insn & fcts_pkg::JALR_SEL) == fcts_pkg::JALR_KEY);
	assign is_ret  = is_jalr && (rd == fcts_pkg::REG_ZERO) && (rs1 == fcts_pkg::REG_RA)
		&& (imm == 12'd0);

	assign s_tready = buf_ready;
	assign accept   = s_tvalid && buf_ready;

	assign empty   = count_q == '0;
	assign full    = count_q >= CW'(fcts_pkg::STACK_DEPTH);
	assign tcallee = empty ? fcts_pkg::MACHINE_ID : top_q.callee;
	assign tcaller = empty ? fcts_pkg::MACHINE_ID : top_q.caller;
	assign below   = fwd_q ? fwd_data_q : ram_rdata;

	always_comb begin
		res              = '0;
		res.event_kind   = fcts_pkg::EV_NONE;
		res.status       = fcts_pkg::ST_OK;
		do_push          = 1'b0;
		do_pop           = 1'b0;
		do_tail          = 1'b0;
		if (is_ret) begin
			res.event_kind = fcts_pkg::EV_RETURN;
			res.caller_id  = tcaller;
			res.callee_id  = tcallee;
			if (empty) begin
				res.status = fcts_pkg::ST_UNDERFLOW;
			end else begin
				do_pop = 1'b1;
			end
		end else if ((is_jal || is_jalr) && is_func) begin
			res.caller_id    = tcallee;
			res.callee_id    = new_id;
			res.event_target = target;
			if (rd == fcts_pkg::REG_RA) begin
				res.event_kind = is_jal ? fcts_pkg::EV_DIRECT : fcts_pkg::EV_INDIRECT;
				if (full) begin
					res.status = fcts_pkg::ST_OVERFLOW;
				end else begin
					do_push = 1'b1;
				end
			end else if (rd == fcts_pkg::REG_ZERO) begin
				res.event_kind = fcts_pkg::EV_TAIL;
				if (empty) begin
					res.status = fcts_pkg::ST_UNDERFLOW;
				end else begin
					do_tail = 1'b1;
				end
			end else begin
				res.status = fcts_pkg::ST_NON_CALL;
			end
		end

		count_next = count_q;
		if (cfg_wen) begin
			count_next = CW'(1);
		end else if (accept && do_push) begin
			count_next = count_q + CW'(1);
		end else if (accept && do_pop) begin
			count_next = count_q - CW'(1);
		end
		res.stack_depth = do_push ? count_q + CW'(1)
			: (do_pop ? count_q - CW'(1) : count_q);
	end

	// spill the old top below the new frame; nothing to spill from an empty stack
	assign wr_en   = accept && do_push && !empty && !cfg_wen;
	assign wr_addr = PW'(count_q - CW'(1));
	// keep the frame below the next top in flight
	assign rd_ptr  = count_next - CW'(2);
	assign rd_addr = rd_ptr[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= CW'(1);
			top_q      <= '{caller: fcts_pkg::MACHINE_ID, callee: '0};
			fwd_q      <= 1'b0;
		end else begin
			count_q <= count_next;
			fwd_q   <= wr_en && (wr_addr == rd_addr);
			if (cfg_wen) begin
				top_q <= '{caller: fcts_pkg::MACHINE_ID, callee: FB'(cfg_wdata)};
			end else if (accept && do_push) begin
				top_q <= '{caller: tcallee, callee: new_id};
			end else if (accept && do_pop) begin
				top_q <= below;
			end else if (accept && do_tail) begin
				top_q.callee <= new_id;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= top_q;
	end

	fcts_stack_ram #(
		.DEPTH (fcts_pkg::STACK_DEPTH),
		.WIDTH (2 * FB)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (top_q),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	fcts_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_ready  (buf_ready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

	assign m_tuser = out_data.event_kind;
	assign m_tdata = {3'b000, out_data.status, out_data.stack_depth, out_data.event_target,
		out_data.callee_id, out_data.caller_id};

endmodule

// ===== design/fcts_checker.sv =====
// Port-level checks for the function call trace stack, bound to the top level.
`timescale 1ns / 1ps

module fcts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic [2:0]  m_tuser
);

	logic [10:0] depth;
	logic [1:0]  status;

	assign depth  = m_tdata[74:64];
	assign status = m_tdata[76:75];

	// hold a stalled word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output word changed");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> depth <= 11'(fcts_pkg::STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == fcts_pkg::ST_OVERFLOW |->
			depth == 11'(fcts_pkg::STACK_DEPTH)
			&& (m_tuser == fcts_pkg::EV_DIRECT || m_tuser == fcts_pkg::EV_INDIRECT))
		else $error("overflow on a stack that is not full");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == fcts_pkg::ST_UNDERFLOW |-> depth == '0)
		else $error("underflow on a stack that is not empty");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == fcts_pkg::EV_NONE && status == fcts_pkg::ST_OK |->
			m_tdata[63:0] == '0)
		else $error("non-event word carries ids or target");

endmodule

bind function_call_trace_stack fcts_checker u_fcts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
